@@ hdl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg - shared types for the sighting session aging table
// Field widths, function and cause codes, register indexes, the table entry
// and result layouts, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  localparam int TAIL_W = 17;
  localparam int TIME_W = 32;

  typedef logic [TAIL_W-1:0] tail_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [1:0]        func_t;
  typedef logic [1:0]        cause_t;
  typedef logic [0:0]        cfg_idx_t;

  // Input functions
  localparam func_t FUNC_SIGHT  = 2'd0;
  localparam func_t FUNC_TICK   = 2'd1;
  localparam func_t FUNC_FLUSH  = 2'd2;

  // Result causes
  localparam cause_t CAUSE_GAP   = 2'd0;
  localparam cause_t CAUSE_AGED  = 2'd1;
  localparam cause_t CAUSE_FLUSH = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t CFG_GAP_TIMEOUT  = 1'd0;
  localparam cfg_idx_t CFG_MIN_DURATION = 1'd1;

  localparam time_t GAP_TIMEOUT_RST  = 32'd100000;
  localparam time_t MIN_DURATION_RST = 32'd1000;

  typedef struct packed {
    tail_t tail;
    time_t first;
    time_t last;
  } entry_t;

  typedef struct packed {
    tail_t  out_tail;
    time_t  first_seen;
    time_t  last_seen;
    cause_t cause;
    logic   last_of_run;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LOOK,
    ST_SIGHT,
    ST_SWEEP_GO,
    ST_SWEEP,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // Entry write kinds
  typedef enum logic [1:0] {
    WR_NEW,
    WR_RESTART,
    WR_EXTEND
  } wsel_t;

  typedef struct packed {
    logic   latch;
    logic   scan_start;
    logic   scan_lookup;
    logic   wr;
    wsel_t  wsel;
    logic   clr_valid;
    logic   emit;
    cause_t cause;
    logic   finish;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  scan_done;
    logic  found;
    logic  free_found;
    logic  match_idle;
    logic  long_dur;
    logic  push_ok;
    logic  hold_vld;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ hdl/sst_in_if.sv @@
// ----------------------------------------------------------------------------
// sst_in_if - input transaction channel
// Valid/ready channel carrying one request: function, tail number, time.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_in_if;
  logic          valid;
  logic          ready;
  sst_pkg::func_t func;
  sst_pkg::tail_t tail_number;
  sst_pkg::time_t event_time;

  modport source (output valid, output func, output tail_number, output event_time,
                  input ready);
  modport sink   (input valid, input func, input tail_number, input event_time,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/sst_out_if.sv @@
// ----------------------------------------------------------------------------
// sst_out_if - result transaction channel
// Valid/ready channel carrying one closed session.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_out_if;
  logic            valid;
  logic            ready;
  sst_pkg::tail_t  out_tail;
  sst_pkg::time_t  first_seen;
  sst_pkg::time_t  last_seen;
  sst_pkg::cause_t cause;
  logic            last_of_run;

  modport source (output valid, output out_tail, output first_seen, output last_seen,
                  output cause, output last_of_run, input ready);
  modport sink   (input valid, input out_tail, input first_seen, input last_seen,
                  input cause, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hdl/sst_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sst_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_cfg_if;
  logic              valid;
  logic              ready;
  sst_pkg::cfg_idx_t idx;
  sst_pkg::time_t    data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/sighting_session_aging_table.sv @@
// ----------------------------------------------------------------------------
// sighting_session_aging_table - open session table keyed by tail number
// Tracks first/last sighting times per tail, closes idle sessions on sweep
// and restart, and emits every open session on flush.
// ----------------------------------------------------------------------------
// Each request is processed to completion before the next is taken. The
// session table lives in a single RAM that is scanned one slot per cycle. A
// sighting costs one lookup pass, an entry update in ST_SIGHT and a scan
// restart in ST_SWEEP_GO, and then a sweep; a position tick is just the
// sweep; a flush is a sweep that selects every session. A sweep runs one
// pass per session it removes plus a final empty pass, always picking the
// lowest tail left, and each removal is decided in ST_DRAIN. A result that
// waits on out_ch can hold the block up, and an unused code returns to idle
// straight from dispatch. Results are staged one deep before the output
// register so the final result of a request can carry last_of_run; the next
// request is accepted while that final result still waits on out_ch. The
// table has per-slot valid bits cleared by reset, so no clearing pass is
// needed. Configuration writes are accepted every cycle and must only be
// issued while no request is in flight.
`default_nettype none

module sighting_session_aging_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  sst_in_if.sink  in_ch,
  sst_out_if.source out_ch,
  sst_cfg_if.sink cfg_ch
);

  sst_pkg::dp_cmd_t cmd;
  sst_pkg::dp_sts_t sts;
  sst_pkg::result_t out_res;
  logic             out_valid;
  logic             in_ready;

  // Register writes never stall.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // Sequencer: one request at a time, drives the datapath by command.
  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, scan engine, staging and output register.
  sst_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_ch.func),
    .in_tail   (in_ch.tail_number),
    .in_time   (in_ch.event_time),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.idx),
    .cfg_data  (cfg_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Drive the result channel from the output register.
  assign out_ch.valid       = out_valid;
  assign out_ch.out_tail    = out_res.out_tail;
  assign out_ch.first_seen  = out_res.first_seen;
  assign out_ch.last_seen   = out_res.last_seen;
  assign out_ch.cause       = out_res.cause;
  assign out_ch.last_of_run = out_res.last_of_run;

  // A real request keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready &&
     (in_ch.func == sst_pkg::FUNC_SIGHT || in_ch.func == sst_pkg::FUNC_TICK ||
      in_ch.func == sst_pkg::FUNC_FLUSH)) |=> !in_ch.ready)
    else $error("request accepted but block did not go busy");

  // Every result of a request has left staging before the next is taken.
  a_hold_empty_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !sts.hold_vld)
    else $error("staged result left behind at request boundary");

  // The output register is loaded only from the staging register.
  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(sts.hold_vld))
    else $error("output became valid without a staged result");

endmodule

`default_nettype wire

@@ hdl/sst_ram.sv @@
// ----------------------------------------------------------------------------
// sst_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/sst_datapath.sv @@
// ----------------------------------------------------------------------------
// sst_datapath - session table, scan engine and result staging
// Holds the session RAM and valid bits, scans slots one per cycle for a tail
// match or the lowest-tail candidate, and stages results toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_datapath #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sst_pkg::dp_cmd_t  cmd,
  output sst_pkg::dp_sts_t  sts,
  input  sst_pkg::func_t    in_func,
  input  sst_pkg::tail_t    in_tail,
  input  sst_pkg::time_t    in_time,
  input  logic              cfg_we,
  input  sst_pkg::cfg_idx_t cfg_idx,
  input  sst_pkg::time_t    cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output sst_pkg::result_t  out_res
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam int ENTRY_W = $bits(sst_pkg::entry_t);

  // Latched request and configuration
  sst_pkg::func_t func_r;
  sst_pkg::tail_t tail_r;
  sst_pkg::time_t now_r;
  sst_pkg::time_t gap_r;
  sst_pkg::time_t min_r;

  // Scan engine
  logic [CNT_W-1:0] cnt_r;
  logic             scanning_r;
  logic             pv_r;
  logic [IDX_W-1:0] pidx_r;
  logic             lookup_r;
  logic             found_r;
  logic [IDX_W-1:0] bslot_r;
  sst_pkg::entry_t  bdata_r;
  logic             free_r;
  logic [IDX_W-1:0] fslot_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  // Result staging
  sst_pkg::result_t hold_r;
  logic             hold_vld_r;
  sst_pkg::result_t out_r;
  logic             out_vld_r;

  logic [ENTRY_W-1:0] ram_rdata;
  sst_pkg::entry_t    rd_entry;
  sst_pkg::entry_t    wr_entry;
  logic [IDX_W-1:0]   wr_addr;
  logic               p_valid;
  logic               p_idle;
  logic               p_cand;
  logic               p_better;
  logic               scan_done;
  logic               b_idle;
  sst_pkg::time_t     dur;
  logic               push_ok;
  sst_pkg::result_t   new_res;
  sst_pkg::result_t   rel_res;

  assign rd_entry = sst_pkg::entry_t'(ram_rdata);

  sst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    wr_addr  = bslot_r;
    wr_entry = bdata_r;
    case (cmd.wsel)
      sst_pkg::WR_NEW: begin
        wr_addr  = fslot_r;
        wr_entry = '{tail: tail_r, first: now_r, last: now_r};
      end
      sst_pkg::WR_RESTART: begin
        wr_entry = '{tail: bdata_r.tail, first: now_r, last: now_r};
      end
      sst_pkg::WR_EXTEND: begin
        wr_entry = '{tail: bdata_r.tail, first: bdata_r.first, last: now_r};
      end
      default: begin
        wr_entry = bdata_r;
      end
    endcase
  end

  // Slot under test this cycle
  assign p_valid  = valid_r[pidx_r];
  assign p_idle   = ({1'b0, rd_entry.last} + {1'b0, gap_r}) < {1'b0, now_r};
  assign p_cand   = lookup_r ? (p_valid && (rd_entry.tail == tail_r))
                             : (p_valid && ((func_r == sst_pkg::FUNC_FLUSH) || p_idle));
  assign p_better = !found_r || (!lookup_r && (rd_entry.tail < bdata_r.tail));
  assign scan_done = scanning_r && (cnt_r == DEPTH_CNT) && !pv_r;

  // Tests on the selected session
  assign b_idle  = ({1'b0, bdata_r.last} + {1'b0, gap_r}) < {1'b0, now_r};
  assign dur     = (bdata_r.last >= bdata_r.first) ? (bdata_r.last - bdata_r.first) : '0;
  assign push_ok = !hold_vld_r || !out_vld_r || out_ready;

  assign new_res = '{out_tail: bdata_r.tail, first_seen: bdata_r.first,
                     last_seen: bdata_r.last, cause: cmd.cause, last_of_run: 1'b0};

  // Released result: its last_of_run flag is decided as it leaves staging.
  always_comb begin
    rel_res             = hold_r;
    rel_res.last_of_run = cmd.finish;
  end

  always_comb begin
    sts            = '0;
    sts.func       = func_r;
    sts.scan_done  = scan_done;
    sts.found      = found_r;
    sts.free_found = free_r;
    sts.match_idle = b_idle;
    sts.long_dur   = dur > min_r;
    sts.push_ok    = push_ok;
    sts.hold_vld   = hold_vld_r;
  end

  // Request and configuration capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      tail_r <= in_tail;
      now_r  <= in_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= sst_pkg::GAP_TIMEOUT_RST;
      min_r <= sst_pkg::MIN_DURATION_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        sst_pkg::CFG_GAP_TIMEOUT:  gap_r <= cfg_data;
        sst_pkg::CFG_MIN_DURATION: min_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
      pv_r       <= 1'b0;
      cnt_r      <= '0;
      found_r    <= 1'b0;
      free_r     <= 1'b0;
    end else if (cmd.scan_start) begin
      scanning_r <= 1'b1;
      pv_r       <= 1'b0;
      cnt_r      <= '0;
      found_r    <= 1'b0;
      free_r     <= 1'b0;
    end else begin
      pv_r <= scanning_r && (cnt_r != DEPTH_CNT);
      if (scanning_r && (cnt_r != DEPTH_CNT)) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (scan_done) begin
        scanning_r <= 1'b0;
      end
      if (pv_r && p_cand && p_better) begin
        found_r <= 1'b1;
      end
      if (pv_r && lookup_r && !p_valid && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= cnt_r[IDX_W-1:0];
    if (cmd.scan_start) begin
      lookup_r <= cmd.scan_lookup;
    end
    if (!cmd.scan_start && pv_r && p_cand && p_better) begin
      bslot_r <= pidx_r;
      bdata_r <= rd_entry;
    end
    if (!cmd.scan_start && pv_r && lookup_r && !p_valid && !free_r) begin
      fslot_r <= pidx_r;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.wr && (cmd.wsel == sst_pkg::WR_NEW)) begin
        valid_r[fslot_r] <= 1'b1;
      end
      if (cmd.clr_valid) begin
        valid_r[bslot_r] <= 1'b0;
      end
    end
  end

  // Result staging: a result waits in hold until the next one or the end of
  // the request decides its last_of_run flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if ((cmd.emit || cmd.finish) && hold_vld_r) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cmd.emit) begin
        hold_vld_r <= 1'b1;
      end else if (cmd.finish) begin
        hold_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.emit || cmd.finish) && hold_vld_r) begin
      out_r <= rel_res;
    end
    if (cmd.emit) begin
      hold_r <= new_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

@@ hdl/sst_ctrl.sv @@
// ----------------------------------------------------------------------------
// sst_ctrl - request sequencer
// Steps a sighting through lookup and entry update, and every sighting, tick or
// flush through sweep passes and the final result release, issuing commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sst_pkg::dp_sts_t sts,
  output sst_pkg::dp_cmd_t cmd
);

  sst_pkg::state_t state_r;
  sst_pkg::state_t state_nxt;
  logic            flush;

  assign flush = (sts.func == sst_pkg::FUNC_FLUSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.wsel  = sst_pkg::WR_EXTEND;
    cmd.cause = sst_pkg::CAUSE_GAP;
    in_ready  = 1'b0;
    case (state_r)
      sst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = sst_pkg::ST_DISPATCH;
        end
      end
      sst_pkg::ST_DISPATCH: begin
        case (sts.func)
          sst_pkg::FUNC_SIGHT: begin
            cmd.scan_start  = 1'b1;
            cmd.scan_lookup = 1'b1;
            state_nxt       = sst_pkg::ST_LOOK;
          end
          sst_pkg::FUNC_TICK, sst_pkg::FUNC_FLUSH: begin
            cmd.scan_start = 1'b1;
            state_nxt      = sst_pkg::ST_SWEEP;
          end
          default: begin
            state_nxt = sst_pkg::ST_IDLE;
          end
        endcase
      end
      sst_pkg::ST_LOOK: begin
        if (sts.scan_done) begin
          state_nxt = sst_pkg::ST_SIGHT;
        end
      end
      sst_pkg::ST_SIGHT: begin
        if (sts.found) begin
          if (sts.match_idle) begin
            if (sts.push_ok) begin
              cmd.emit  = 1'b1;
              cmd.cause = sst_pkg::CAUSE_GAP;
              cmd.wr    = 1'b1;
              cmd.wsel  = sst_pkg::WR_RESTART;
              state_nxt = sst_pkg::ST_SWEEP_GO;
            end
          end else begin
            cmd.wr    = 1'b1;
            cmd.wsel  = sst_pkg::WR_EXTEND;
            state_nxt = sst_pkg::ST_SWEEP_GO;
          end
        end else begin
          if (sts.free_found) begin
            cmd.wr   = 1'b1;
            cmd.wsel = sst_pkg::WR_NEW;
          end
          state_nxt = sst_pkg::ST_SWEEP_GO;
        end
      end
      sst_pkg::ST_SWEEP_GO: begin
        cmd.scan_start = 1'b1;
        state_nxt      = sst_pkg::ST_SWEEP;
      end
      sst_pkg::ST_SWEEP: begin
        if (sts.scan_done) begin
          state_nxt = sst_pkg::ST_DRAIN;
        end
      end
      sst_pkg::ST_DRAIN: begin
        if (!sts.found) begin
          state_nxt = sst_pkg::ST_FIN;
        end else if (flush || sts.long_dur) begin
          if (sts.push_ok) begin
            cmd.emit       = 1'b1;
            cmd.cause      = flush ? sst_pkg::CAUSE_FLUSH : sst_pkg::CAUSE_AGED;
            cmd.clr_valid  = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = sst_pkg::ST_SWEEP;
          end
        end else begin
          cmd.clr_valid  = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = sst_pkg::ST_SWEEP;
        end
      end
      sst_pkg::ST_FIN: begin
        if (!sts.hold_vld) begin
          state_nxt = sst_pkg::ST_IDLE;
        end else if (sts.push_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = sst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ tb/tb_sighting_session_aging_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sighting_session_aging_table - self-checking bench for the session table
// Drives sightings, position ticks, flushes and unused codes through the
// input channel and predicts every closed session in ascending tail order.
// Each result is checked field by field against that prediction. The run
// covers directed boundary cases, a full table and random session traffic
// under changing handshake pressure and register settings.
// ----------------------------------------------------------------------------

module tb_sighting_session_aging_table;

  localparam int             TABLE_DEPTH   = 32;
  // Covers the slowest silent request: a sighting that removes all 32 sessions
  // over 34 scan passes, with margin.
  localparam int             SETTLE_CYCLES = 1300;
  localparam int             STALL_LIMIT   = 20000;
  localparam int             PRINT_LIMIT   = 50;
  localparam sst_pkg::time_t TIME_MAX      = 32'hFFFF_FFFF;
  localparam sst_pkg::tail_t TAIL_MAX      = 17'h1FFFF;
  localparam sst_pkg::func_t FUNC_UNUSED   = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  sst_in_if  in_ch();
  sst_out_if out_ch();
  sst_cfg_if cfg_ch();

  sighting_session_aging_table #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the session table and of the two registers.
  logic           open_valid [TABLE_DEPTH];
  sst_pkg::tail_t open_tail  [TABLE_DEPTH];
  sst_pkg::time_t open_first [TABLE_DEPTH];
  sst_pkg::time_t open_last  [TABLE_DEPTH];
  sst_pkg::time_t gap_ms;
  sst_pkg::time_t min_dur_ms;

  // Sessions closed by the request being predicted, then all sessions still
  // owed by the block, oldest first.
  sst_pkg::result_t run_closures[$];
  sst_pkg::result_t pending_closures[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int closures_seen = 0;
  int sightings_sent = 0;
  int ticks_sent     = 0;
  int flushes_sent   = 0;
  int unused_sent    = 0;
  int quiet_cycles   = 0;

  // --------------------------------------------------------------------------
  // Session predictor
  // --------------------------------------------------------------------------

  // Idle when last + gap, formed at 33 bits, lies strictly below now.
  function automatic logic gone_idle(int s, sst_pkg::time_t now);
    logic [32:0] limit;
    limit = {1'b0, open_last[s]} + {1'b0, gap_ms};
    return limit < {1'b0, now};
  endfunction

  function automatic sst_pkg::result_t make_closure(int s, sst_pkg::cause_t why);
    sst_pkg::result_t r;
    r.out_tail    = open_tail[s];
    r.first_seen  = open_first[s];
    r.last_seen   = open_last[s];
    r.cause       = why;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Remove every marked session, lowest tail first. Aged sessions are only
  // reported when last - first (floored at zero) exceeds min_duration.
  function automatic void close_sessions(logic [TABLE_DEPTH-1:0] mask,
                                         sst_pkg::cause_t why);
    int             pick;
    sst_pkg::time_t span;
    while (mask != '0) begin
      pick = -1;
      for (int s = 0; s < TABLE_DEPTH; s++)
        if (mask[s] && (pick < 0 || open_tail[s] < open_tail[pick]))
          pick = s;
      mask[pick] = 1'b0;
      span = (open_last[pick] >= open_first[pick]) ? open_last[pick] - open_first[pick] : '0;
      if (why != sst_pkg::CAUSE_AGED || span > min_dur_ms)
        run_closures = {run_closures, make_closure(pick, why)};
      open_valid[pick] = 1'b0;
    end
  endfunction

  function automatic void sweep_table(sst_pkg::time_t now);
    logic [TABLE_DEPTH-1:0] mask;
    for (int s = 0; s < TABLE_DEPTH; s++)
      mask[s] = open_valid[s] && gone_idle(s, now);
    close_sessions(mask, sst_pkg::CAUSE_AGED);
  endfunction

  // Extend, restart or open the tail's session; drop it when the table is full.
  function automatic void log_sighting(sst_pkg::tail_t tail, sst_pkg::time_t now);
    int free_slot;
    free_slot = -1;
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      if (open_valid[s] && open_tail[s] == tail) begin
        if (gone_idle(s, now)) begin
          run_closures = {run_closures, make_closure(s, sst_pkg::CAUSE_GAP)};
          open_first[s] = now;
        end
        open_last[s] = now;
        return;
      end
      if (!open_valid[s] && free_slot < 0)
        free_slot = s;
    end
    if (free_slot >= 0) begin
      open_valid[free_slot] = 1'b1;
      open_tail[free_slot]  = tail;
      open_first[free_slot] = now;
      open_last[free_slot]  = now;
    end
  endfunction

  function automatic void predict_closures(sst_pkg::func_t op, sst_pkg::tail_t tail,
                                           sst_pkg::time_t now);
    logic [TABLE_DEPTH-1:0] all_open;
    run_closures.delete();
    case (op)
      sst_pkg::FUNC_SIGHT: begin
        log_sighting(tail, now);
        sweep_table(now);
      end
      sst_pkg::FUNC_TICK: sweep_table(now);
      sst_pkg::FUNC_FLUSH: begin
        for (int s = 0; s < TABLE_DEPTH; s++)
          all_open[s] = open_valid[s];
        close_sessions(all_open, sst_pkg::CAUSE_FLUSH);
      end
      default: ;
    endcase
    // Mark the final closure of this request.
    if (run_closures.size() > 0)
      run_closures[run_closures.size()-1].last_of_run = 1'b1;
    pending_closures = {pending_closures, run_closures};
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < PRINT_LIMIT)
      $display("%0t MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Compare every accepted closure with the oldest prediction.
  always @(posedge clk) begin : check_closures
    sst_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      closures_seen++;
      if (pending_closures.size() == 0) begin
        report_mismatch("closure with nothing pending, tail", 32'(out_ch.out_tail), '0);
      end else begin
        want = pending_closures.pop_front();
        if (out_ch.out_tail !== want.out_tail)
          report_mismatch("out_tail", 32'(out_ch.out_tail), 32'(want.out_tail));
        if (out_ch.first_seen !== want.first_seen)
          report_mismatch("first_seen", out_ch.first_seen, want.first_seen);
        if (out_ch.last_seen !== want.last_seen)
          report_mismatch("last_seen", out_ch.last_seen, want.last_seen);
        if (out_ch.cause !== want.cause)
          report_mismatch("cause", 32'(out_ch.cause), 32'(want.cause));
        if (out_ch.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 32'(out_ch.last_of_run), 32'(want.last_of_run));
      end
    end
  end

  // Drop ready at random; the idle share follows the current phase.
  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  // Watchdog: abort when no transaction moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb_sighting_session_aging_table: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one request and predict its closures once the transaction is
  // accepted. Valid is left high on return: the next call either replaces
  // the payload or drops valid, so it never toggles within one step.
  task automatic send_request(sst_pkg::func_t op, sst_pkg::tail_t tail,
                              sst_pkg::time_t now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= op;
    in_ch.tail_number <= tail;
    in_ch.event_time  <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_closures(op, tail, now);
    case (op)
      sst_pkg::FUNC_SIGHT: sightings_sent++;
      sst_pkg::FUNC_TICK:  ticks_sent++;
      sst_pkg::FUNC_FLUSH: flushes_sent++;
      default:             unused_sent++;
    endcase
  endtask

  // Hold the input channel until every predicted closure has been taken.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_closures.size() != 0) @(posedge clk);
  endtask

  // Let a silent request finish, then write both registers back to back.
  task automatic settle_then_configure(sst_pkg::time_t gap, sst_pkg::time_t min_dur);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= sst_pkg::CFG_GAP_TIMEOUT;
    cfg_ch.data  <= gap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    gap_ms = gap;
    cfg_ch.idx  <= sst_pkg::CFG_MIN_DURATION;
    cfg_ch.data <= min_dur;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    min_dur_ms = min_dur;
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset registers: gap 100000 ms, minimum duration 1000 ms.
  task automatic test_directed_defaults();
    send_request(sst_pkg::FUNC_SIGHT, 17'd0, 32'd0);
    send_request(sst_pkg::FUNC_SIGHT, 17'd99999, 32'd10);
    send_request(sst_pkg::FUNC_SIGHT, TAIL_MAX, 32'd20);   // largest tail number
    send_request(sst_pkg::FUNC_SIGHT, 17'd0, 32'd5000);    // extend
    send_request(sst_pkg::FUNC_TICK, 17'd0, 32'd100010);   // last + gap equals now: stays open
    send_request(sst_pkg::FUNC_TICK, 17'd0, 32'd100021);   // two short sessions age silently
    send_request(sst_pkg::FUNC_SIGHT, 17'd0, 32'd200000);  // idle session restarts
    send_request(sst_pkg::FUNC_SIGHT, 17'd5, 32'd200500);
    send_request(sst_pkg::FUNC_SIGHT, 17'd5, 32'd202000);  // 1500 ms long
    send_request(sst_pkg::FUNC_SIGHT, 17'd3, 32'd202000);
    send_request(sst_pkg::FUNC_SIGHT, 17'd3, 32'd203000);  // exactly the minimum: not reported
    send_request(sst_pkg::FUNC_TICK, 17'd0, 32'd303001);
    send_request(FUNC_UNUSED, 17'd7, 32'd999999);          // ignored code
    send_request(sst_pkg::FUNC_SIGHT, 17'd7, 32'd400000);
    send_request(sst_pkg::FUNC_SIGHT, 17'd2, 32'd400001);
    send_request(sst_pkg::FUNC_SIGHT, 17'd9, 32'd401500);
    send_request(sst_pkg::FUNC_FLUSH, 17'd0, 32'd0);       // ascending tails, no length test
    send_request(sst_pkg::FUNC_FLUSH, 17'd0, 32'd0);       // empty table
  endtask

  task automatic test_directed_extremes();
    // Zero gap and zero minimum: any later sighting restarts.
    settle_then_configure(32'd0, 32'd0);
    send_request(sst_pkg::FUNC_SIGHT, 17'd40, 32'd1000);
    send_request(sst_pkg::FUNC_SIGHT, 17'd40, 32'd1000);
    send_request(sst_pkg::FUNC_SIGHT, 17'd40, 32'd1001);
    send_request(sst_pkg::FUNC_SIGHT, 17'd41, 32'd1001);
    send_request(sst_pkg::FUNC_SIGHT, 17'd41, 32'd500);    // time goes backwards
    send_request(sst_pkg::FUNC_TICK, 17'd0, 32'd2000);     // negative span floors at zero
    // Largest gap and minimum: the 33-bit sum never ages a session.
    settle_then_configure(TIME_MAX, TIME_MAX);
    send_request(sst_pkg::FUNC_SIGHT, 17'd50, 32'd0);
    send_request(sst_pkg::FUNC_SIGHT, 17'd50, TIME_MAX);
    send_request(sst_pkg::FUNC_TICK, 17'd0, TIME_MAX);
    send_request(sst_pkg::FUNC_FLUSH, 17'd0, TIME_MAX);
    // Age a session at the top of the time range.
    settle_then_configure(32'd10, 32'd5);
    send_request(sst_pkg::FUNC_SIGHT, 17'd70, 32'hFFFF_FFE0);
    send_request(sst_pkg::FUNC_SIGHT, 17'd70, 32'hFFFF_FFE8);
    send_request(sst_pkg::FUNC_TICK, 17'd0, TIME_MAX);
  endtask

  // Fill every slot with distinct tails, overflow it, then flush.
  task automatic test_table_full();
    sst_pkg::tail_t base;
    sst_pkg::tail_t stride;
    sst_pkg::time_t start;
    settle_then_configure(32'd1_000_000, 32'd0);
    base   = sst_pkg::tail_t'($urandom_range(131071));
    stride = sst_pkg::tail_t'($urandom_range(1, 3000));
    start  = $urandom_range(32'h4000_0000);
    for (int i = 0; i < TABLE_DEPTH + 2; i++)
      send_request(sst_pkg::FUNC_SIGHT, base + sst_pkg::tail_t'(i) * stride, start + i * 10);
    send_request(sst_pkg::FUNC_SIGHT, base, start + 1000);   // extend a stored tail
    send_request(sst_pkg::FUNC_SIGHT, base + sst_pkg::tail_t'(TABLE_DEPTH) * stride,
                 start + 1001);
    send_request(sst_pkg::FUNC_TICK, 17'd0, start + 2000);
    send_request(sst_pkg::FUNC_FLUSH, 17'd0, start + 2000);
  endtask

  // Random sessions over a small tail pool so tails recur, with jumps past
  // the gap, occasional backward steps and stray tails.
  task automatic run_random_segment(int count, sst_pkg::time_t gap);
    sst_pkg::tail_t pool [12];
    logic [32:0]    clock_ms;
    sst_pkg::time_t step;
    sst_pkg::tail_t tail;
    sst_pkg::func_t op;
    int             roll;
    int             sent;
    foreach (pool[i])
      pool[i] = ($urandom_range(9) == 0) ? sst_pkg::tail_t'($urandom_range(131071))
                                         : sst_pkg::tail_t'($urandom_range(99999));
    clock_ms = 33'($urandom_range(32'hF000_0000));
    sent = 0;
    while (sent < count) begin
      // Pause the sender at the segment's midpoint until everything has drained.
      if (sent == count / 2)
        hold_until_drained();
      roll = $urandom_range(99);
      if (roll < 70)      op = sst_pkg::FUNC_SIGHT;
      else if (roll < 88) op = sst_pkg::FUNC_TICK;
      else if (roll < 95) op = sst_pkg::FUNC_FLUSH;
      else                op = FUNC_UNUSED;
      roll = $urandom_range(99);
      if (roll < 75) begin
        clock_ms = clock_ms + $urandom_range(gap / 4 + 1);
      end else if (roll < 92) begin
        clock_ms = clock_ms + gap + $urandom_range(2 * gap);
      end else if (roll < 97) begin
        step = $urandom_range(gap);
        clock_ms = (clock_ms > step) ? clock_ms - step : '0;
      end
      if (clock_ms > TIME_MAX)
        clock_ms = {1'b0, TIME_MAX};
      tail = ($urandom_range(4) == 0) ? sst_pkg::tail_t'($urandom_range(131071))
                                      : pool[$urandom_range(11)];
      send_request(op, tail, clock_ms[31:0]);
      if (op != FUNC_UNUSED)
        sent++;
    end
  endtask

  task automatic test_random_traffic();
    sst_pkg::time_t gap;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 21; recv_idle_pct = 83; end
        1: begin send_idle_pct = 83; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        gap = $urandom_range(20, 5000);
        settle_then_configure(gap, $urandom_range(gap));
        run_random_segment(40, gap);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= sst_pkg::FUNC_TICK;
    in_ch.tail_number <= '0;
    in_ch.event_time  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.idx        <= sst_pkg::CFG_GAP_TIMEOUT;
    cfg_ch.data       <= '0;
    gap_ms     = sst_pkg::GAP_TIMEOUT_RST;
    min_dur_ms = sst_pkg::MIN_DURATION_RST;
    foreach (open_valid[s])
      open_valid[s] = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed and table-full checks run with a lazy receiver.
    send_idle_pct = 21;
    recv_idle_pct = 83;
    test_directed_defaults();
    test_directed_extremes();
    test_table_full();
    test_random_traffic();

    // Drain, then give any trailing silent request time to finish.
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d sightings, %0d position ticks, %0d flushes, %0d unused codes",
             sightings_sent, ticks_sent, flushes_sent, unused_sent);
    $display("checked %0d closed sessions over six register settings plus extremes, %0d mismatches",
             closures_seen, error_count);
    if (error_count == 0) begin
      $display("tb_sighting_session_aging_table: done, clean");
    end else begin
      $display("tb_sighting_session_aging_table: done, errors");
    end
    $finish;
  end

endmodule

@@ sighting_session_aging_table.f @@
hdl/sst_pkg.sv
hdl/sst_in_if.sv
hdl/sst_out_if.sv
hdl/sst_cfg_if.sv
hdl/sst_ram.sv
hdl/sst_datapath.sv
hdl/sst_ctrl.sv
hdl/sighting_session_aging_table.sv
tb/tb_sighting_session_aging_table.sv
